@@ sv/one_wire_bus_master_defines.svh @@
// ---------------------------------------------------------------------------
// 1-Wire bus master: assertion macros
// Shared concurrent assertion wrappers, clocked on clock.
// ---------------------------------------------------------------------------
`ifndef ONE_WIRE_BUS_MASTER_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_DEFINES_SVH

// Checked outside reset only.
`define OWM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define OWM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/owm_pkg.sv @@
// ---------------------------------------------------------------------------
// 1-Wire bus master package
// Widths, command codes, register indexes and shared structs.
// ---------------------------------------------------------------------------
package owm_pkg;

   localparam int unsigned BITS_PER_BYTE = 8;
   localparam int unsigned BIT_IDX_W     = $clog2(BITS_PER_BYTE);
   localparam int unsigned TICK_W        = 10;
   localparam int unsigned NUM_REGS      = 8;
   localparam int unsigned CSR_IDX_W     = $clog2(NUM_REGS);

   localparam logic [BIT_IDX_W-1:0] BIT_LAST = BIT_IDX_W'(BITS_PER_BYTE - 1);

   // command codes
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_RESET = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;
   localparam logic [1:0] MODE_READ  = 2'd3;

   // timing register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RESET_LOW    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_PRESENCE     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_RESET_RECOV  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_WRITE_START  = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_WRITE_HOLD   = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_READ_START   = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] REG_READ_SAMPLE  = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] REG_READ_RECOV   = CSR_IDX_W'(7);

   typedef logic [NUM_REGS-1:0][TICK_W-1:0] cfg_type;

   localparam cfg_type CFG_RESET = {
      TICK_W'(50),  TICK_W'(5),  TICK_W'(5),   TICK_W'(50),
      TICK_W'(10),  TICK_W'(500), TICK_W'(75), TICK_W'(500)
   };

   typedef struct packed {
      logic [1:0]                mode;
      logic [BITS_PER_BYTE-1:0]  write_byte;
      logic                      line_level;
   } item_type;

   typedef struct packed {
      logic                      drive_low;
      logic                      busy_res;
      logic                      done_res;
      logic                      presence;
      logic [BITS_PER_BYTE-1:0]  read_data;
   } result_type;

endpackage

@@ sv/owm_regs.sv @@
// ---------------------------------------------------------------------------
// 1-Wire bus master timing registers
// Eight 10-bit slot timing registers, loaded with defaults at reset.
// ---------------------------------------------------------------------------
module owm_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [owm_pkg::CSR_IDX_W-1:0]   wr_index,
   input  logic [owm_pkg::TICK_W-1:0]      wr_data,
   output owm_pkg::cfg_type                cfg
);
   import owm_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (wr_en) begin
         cfg_ff[wr_index] <= wr_data;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/owm_core.sv @@
// ---------------------------------------------------------------------------
// 1-Wire bus master sequencer
// Phase, tick and bit state; one tick processed per step.
// ---------------------------------------------------------------------------
`include "one_wire_bus_master_defines.svh"

module owm_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  owm_pkg::item_type    item,
   input  owm_pkg::cfg_type     cfg,
   output owm_pkg::result_type  result
);
   import owm_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RST_LOW,
      PH_RST_WAIT,
      PH_RST_RECOV,
      PH_WR_START,
      PH_WR_HOLD,
      PH_RD_START,
      PH_RD_WAIT,
      PH_RD_RECOV
   } phase_type;

   phase_type                 phase_ff, phase_in, ph;
   logic [TICK_W-1:0]         tick_count_ff, tick_count_in, tick;
   logic [BIT_IDX_W-1:0]      bit_index_ff, bit_index_in, bidx;
   logic [BITS_PER_BYTE-1:0]  shift_byte_ff, shift_byte_in, shift;
   logic                      presence_ff, presence_in;
   logic [BITS_PER_BYTE-1:0]  last_read_ff, last_read_in;
   logic [TICK_W-1:0]         len;
   logic                      last_tick, last_bit;
   logic                      drive, busy, done;

   function automatic logic [TICK_W-1:0] phase_len(phase_type p, cfg_type c);
      logic [TICK_W-1:0] v;
      case (p)
         PH_RST_LOW:   v = c[REG_RESET_LOW];
         PH_RST_WAIT:  v = c[REG_PRESENCE];
         PH_RST_RECOV: v = c[REG_RESET_RECOV];
         PH_WR_START:  v = c[REG_WRITE_START];
         PH_WR_HOLD:   v = c[REG_WRITE_HOLD];
         PH_RD_START:  v = c[REG_READ_START];
         PH_RD_WAIT:   v = c[REG_READ_SAMPLE];
         default:      v = c[REG_READ_RECOV];
      endcase
      return v;
   endfunction

   always_comb begin
      ph    = phase_ff;
      tick  = tick_count_ff;
      bidx  = bit_index_ff;
      shift = shift_byte_ff;
      // a command is taken only from idle; its tick is the first of the op
      if (phase_ff == PH_IDLE && item.mode != MODE_TICK) begin
         tick = '0;
         bidx = '0;
         case (item.mode)
            MODE_RESET: ph = PH_RST_LOW;
            MODE_WRITE: begin
               shift = item.write_byte;
               ph    = PH_WR_START;
            end
            default: begin
               shift = '0;
               ph    = PH_RD_START;
            end
         endcase
      end

      len       = phase_len(ph, cfg);
      // zero length behaves as one tick
      last_tick = ({1'b0, tick} + (TICK_W + 1)'(1)) >= {1'b0, len};
      last_bit  = (bidx == BIT_LAST);

      phase_in      = ph;
      tick_count_in = tick;
      bit_index_in  = bidx;
      shift_byte_in = shift;
      presence_in   = presence_ff;
      last_read_in  = last_read_ff;
      drive         = 1'b0;
      busy          = 1'b0;
      done          = 1'b0;

      if (ph != PH_IDLE) begin
         busy = 1'b1;
         case (ph)
            PH_RST_LOW, PH_WR_START, PH_RD_START: drive = 1'b1;
            PH_WR_HOLD:                           drive = ~shift[bidx];
            default:                              drive = 1'b0;
         endcase
         if (!last_tick) begin
            tick_count_in = tick + TICK_W'(1);
         end else begin
            tick_count_in = '0;
            case (ph)
               PH_RST_LOW:  phase_in = PH_RST_WAIT;
               PH_RST_WAIT: begin
                  presence_in = ~item.line_level;
                  phase_in    = PH_RST_RECOV;
               end
               PH_RST_RECOV: begin
                  done     = 1'b1;
                  phase_in = PH_IDLE;
               end
               PH_WR_START: phase_in = PH_WR_HOLD;
               PH_WR_HOLD: begin
                  if (last_bit) begin
                     done     = 1'b1;
                     phase_in = PH_IDLE;
                  end else begin
                     bit_index_in = bidx + BIT_IDX_W'(1);
                     phase_in     = PH_WR_START;
                  end
               end
               PH_RD_START: phase_in = PH_RD_WAIT;
               PH_RD_WAIT: begin
                  if (item.line_level) begin
                     shift_byte_in[bidx] = 1'b1;
                  end
                  phase_in = PH_RD_RECOV;
               end
               default: begin
                  if (last_bit) begin
                     last_read_in = shift;
                     done         = 1'b1;
                     phase_in     = PH_IDLE;
                  end else begin
                     bit_index_in = bidx + BIT_IDX_W'(1);
                     phase_in     = PH_RD_START;
                  end
               end
            endcase
         end
      end

      result.drive_low = drive;
      result.busy_res  = busy;
      result.done_res  = done;
      result.presence  = presence_in;
      result.read_data = last_read_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_count_ff <= '0;
         bit_index_ff  <= '0;
         shift_byte_ff <= '0;
         presence_ff   <= 1'b0;
         last_read_ff  <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         tick_count_ff <= tick_count_in;
         bit_index_ff  <= bit_index_in;
         shift_byte_ff <= shift_byte_in;
         presence_ff   <= presence_in;
         last_read_ff  <= last_read_in;
      end
   end

   `OWM_ASSERT(a_done_to_idle, step && result.done_res |=> phase_ff == PH_IDLE, "done without idle")
   `OWM_ASSERT(a_cmd_starts, step && phase_ff == PH_IDLE && item.mode != MODE_TICK |=> phase_ff != PH_IDLE, "command not started")
   `OWM_ASSERT(a_hold_state, !step |=> $stable(phase_ff) && $stable(bit_index_ff) && $stable(tick_count_ff), "state moved without a step")
   `OWM_ASSERT_ALWAYS(a_idle_quiet, phase_ff == PH_IDLE && item.mode == MODE_TICK |-> !result.busy_res && !result.drive_low, "idle tick drives bus")

endmodule

@@ sv/one_wire_bus_master.sv @@
// ---------------------------------------------------------------------------
// 1-Wire bus master
// Tick-driven reset, write-byte and read-byte sequencer with timing CSRs.
// ---------------------------------------------------------------------------
// Each req beat is one bus tick (normally 1 us) carrying an optional command
// and the sampled line level; each tick yields exactly one rsp beat with the
// drive level for that tick plus busy, done, presence and last read byte.
// The block takes one beat per clock while rsp_ready does not stall it: a
// request lands in an input register, the sequencer works it out in one
// pass and the result sits in an output register, so throughput is one tick
// per cycle; rsp_valid rises when that register loads, held back only while
// rsp_ready holds it full. Commands arriving while busy, including on
// the finishing tick, are dropped. Slot timings are set through the csr_
// port (index 0..7, 10-bit tick counts, a count of zero acts as one) and
// should only be changed while the bus is idle and no beats are in flight.
// ---------------------------------------------------------------------------
module one_wire_bus_master (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_mode,
   input  logic [owm_pkg::BITS_PER_BYTE-1:0]    req_write_byte,
   input  logic                                 req_line_level,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_drive_low,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_done_res,
   output logic                                 rsp_presence,
   output logic [owm_pkg::BITS_PER_BYTE-1:0]    rsp_read_data,
   // timing register write
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [owm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [owm_pkg::TICK_W-1:0]           csr_wdata
);
   import owm_pkg::*;

   cfg_type     cfg;
   item_type    item_ff;
   logic        in_valid_ff;
   result_type  result;
   result_type  result_ff;
   logic        rsp_valid_ff;
   logic        advance;
   logic        step;

   // output slot free or being drained this cycle
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   owm_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   owm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // handshake control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.mode       <= req_mode;
         item_ff.write_byte <= req_write_byte;
         item_ff.line_level <= req_line_level;
      end
      if (step) begin
         result_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive_low = result_ff.drive_low;
   assign rsp_busy_res  = result_ff.busy_res;
   assign rsp_done_res  = result_ff.done_res;
   assign rsp_presence  = result_ff.presence;
   assign rsp_read_data = result_ff.read_data;

endmodule
